// ----- hdl/blsu_pkg.sv -----
`default_nettype none
package blsu_pkg;

	localparam int HIDDEN_MAX_DEF = 32;
	localparam int INPUT_MAX_DEF  = 32;
	localparam int STEPS_MAX_DEF  = 64;
	localparam int LAYERS_MAX_DEF = 2;

	localparam logic [1:0] MODE_WEIGHT  = 2'd0;
	localparam logic [1:0] MODE_BIAS    = 2'd1;
	localparam logic [1:0] MODE_FEATURE = 2'd2;
	localparam logic [1:0] MODE_READ    = 2'd3;

	localparam logic [1:0] REG_LAYERS = 2'd0;
	localparam logic [1:0] REG_BIDIR  = 2'd1;
	localparam logic [1:0] REG_HIDDEN = 2'd2;
	localparam logic [1:0] REG_INPUT  = 2'd3;

	localparam logic KIND_DONE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic [1:0] layer_count;
		logic       bidirectional;
		logic [5:0] hidden_size;
		logic [5:0] input_size;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [1:0]         slot;
		logic               matrix_sel;
		logic [5:0]         time_step;
		logic [11:0]        word_addr;
		logic signed [15:0] data_value;
		logic               last_element;
	} item_t;

	typedef struct packed {
		logic               valid;
		logic               kind;
		logic signed [15:0] value;
	} res_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef struct packed {
		logic               mul_en;
		logic signed [15:0] mul_a;
		logic signed [15:0] mul_b;
		acc_op_t            acc_op;
		logic signed [31:0] load_val;
	} mac_ctrl_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_START,
		ST_DIR,
		ST_LAYER,
		ST_UNIT,
		ST_BH,
		ST_BX,
		ST_BINIT,
		ST_HH_RD,
		ST_HH_MUL,
		ST_HH_ACC,
		ST_X_RD,
		ST_X_MUL,
		ST_X_ACC,
		ST_GWR,
		ST_U_RI,
		ST_U_RF,
		ST_U_RG,
		ST_U_RO,
		ST_U_M1,
		ST_U_A1,
		ST_U_A2,
		ST_U_C,
		ST_U_H1,
		ST_U_H2,
		ST_DONE
	} state_t;

	typedef logic signed [15:0] tab_t [1024];

	// shift and subtract quotient, evaluated only while the tables are built
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic tab_t build_tab(input logic is_tanh);
		tab_t        r;
		logic [63:0] e [1025];
		logic [63:0] d;
		logic [63:0] v;
		int          a;
		int          m;
		e[0] = 64'h1_0000_0000;
		for (int k = 1; k <= 1024; k++) begin
			e[k] = (e[k-1] * 64'd4228380000) >> 32;
		end
		for (int k = 0; k < 1024; k++) begin
			m = k - 512;
			a = (m < 0) ? -m : m;
			if (!is_tanh) begin
				d = 64'h1_0000_0000 + e[a];
				v = udiv64((64'd1 << 40) + (d >> 1), d);
				r[k] = (m < 0) ? 16'(256 - v) : v[15:0];
			end else begin
				d = 64'h1_0000_0000 + e[2*a];
				v = udiv64(((64'h1_0000_0000 - e[2*a]) * 64'd256) + (d >> 1), d);
				r[k] = (m < 0) ? 16'(-v) : v[15:0];
			end
		end
		return r;
	endfunction

	localparam tab_t SIG_TAB  = build_tab(1'b0);
	localparam tab_t TANH_TAB = build_tab(1'b1);

	function automatic logic [9:0] tab_idx(input logic signed [15:0] x);
		logic [15:0] s;
		s = x + 16'sd2048;
		if (x < -16'sd2048)
			return 10'd0;
		else if (x > 16'sd2047)
			return 10'd1023;
		else
			return s[11:2];
	endfunction

	function automatic logic signed [15:0] sat16_q8(input logic signed [31:0] v);
		logic signed [31:0] s;
		s = v >>> 8;
		if (s > 32'sd32767)
			return 16'sd32767;
		else if (s < -32'sd32768)
			return -16'sd32768;
		else
			return s[15:0];
	endfunction

endpackage
`default_nettype wire

// ----- hdl/blsu_ram.sv -----
`default_nettype none
module blsu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- hdl/blsu_mac.sv -----
`default_nettype none
module blsu_mac (
	input  wire logic                      clk,
	input  wire blsu_pkg::mac_ctrl_t       ctrl,
	output logic signed [31:0]             prod_s1,
	output logic signed [31:0]             acc_q
);
	import blsu_pkg::*;

	logic signed [32:0] sum;
	logic signed [31:0] sum_sat;

	always_comb begin
		sum = {acc_q[31], acc_q} + {prod_s1[31], prod_s1};
		if (sum[32] != sum[31])
			sum_sat = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			sum_sat = sum[31:0];
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en)
			prod_s1 <= ctrl.mul_a * ctrl.mul_b;
		unique case (ctrl.acc_op)
			ACC_LOAD: acc_q <= ctrl.load_val;
			ACC_ADD:  acc_q <= sum_sat;
			default:  acc_q <= acc_q;
		endcase
	end
endmodule
`default_nettype wire

// ----- hdl/blsu_core.sv -----
`default_nettype none
module blsu_core #(
	parameter int HIDDEN_MAX = blsu_pkg::HIDDEN_MAX_DEF,
	parameter int INPUT_MAX  = blsu_pkg::INPUT_MAX_DEF,
	parameter int STEPS_MAX  = blsu_pkg::STEPS_MAX_DEF,
	parameter int LAYERS_MAX = blsu_pkg::LAYERS_MAX_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire blsu_pkg::cfg_t cfg,
	input  wire blsu_pkg::item_t cmd,
	input  wire logic           cmd_valid,
	output blsu_pkg::res_t      res,
	output logic                busy
);
	import blsu_pkg::*;

	localparam int ROW_MAX    = (INPUT_MAX > HIDDEN_MAX) ? INPUT_MAX : HIDDEN_MAX;
	localparam int MAT_WORDS  = 4 * HIDDEN_MAX * ROW_MAX;
	localparam int BIAS_WORDS = 4 * HIDDEN_MAX;
	localparam int SLOTS      = 2 * LAYERS_MAX;
	localparam int OUT_ROW    = 2 * HIDDEN_MAX;
	localparam int W_DEPTH    = SLOTS * 2 * MAT_WORDS;
	localparam int B_DEPTH    = SLOTS * 2 * BIAS_WORDS;
	localparam int S_DEPTH    = STEPS_MAX * INPUT_MAX;
	localparam int O_DEPTH    = STEPS_MAX * OUT_ROW;
	localparam int G_DEPTH    = 4 * HIDDEN_MAX;
	localparam int V_DEPTH    = LAYERS_MAX * HIDDEN_MAX;
	localparam int WW = $clog2(W_DEPTH);
	localparam int BW = $clog2(B_DEPTH);
	localparam int SW = (S_DEPTH > 1) ? $clog2(S_DEPTH) : 1;
	localparam int OW = (O_DEPTH > 1) ? $clog2(O_DEPTH) : 1;
	localparam int GW = $clog2(G_DEPTH);
	localparam int VW = (V_DEPTH > 1) ? $clog2(V_DEPTH) : 1;
	localparam int CW = $clog2(ROW_MAX + 1);
	localparam int MW = $clog2(MAT_WORDS + 1);

	state_t state_q, state_d;

	logic [CW-1:0] h_eff, n_eff, size;
	logic          l_last;
	int            slot_i;

	logic          d_q;
	logic          l_q;
	logic [6:0]    t_q, steps_q, src_q;
	logic [CW-1:0] q_q, i_q;
	logic [1:0]    g_q;
	logic [MW-1:0] hs_q, hh_q, qs_q, qh_q, rowx_q, rowh_q;
	logic signed [15:0] bh_q, gi_q, gf_q, gg_q, go_q, c_q;
	logic [V_DEPTH-1:0] hv_q, cv_q;
	logic          hrd_v_s1, crd_v_s1;
	logic          rd_pend_q, rd_ok_q;

	logic          w_we, b_we, s_we, o_we, g_we, h_we, c_we;
	logic [WW-1:0] w_waddr, w_raddr;
	logic [BW-1:0] b_waddr, b_raddr;
	logic [SW-1:0] s_waddr, s_raddr;
	logic [OW-1:0] o_waddr, o_raddr;
	logic [GW-1:0] g_waddr, g_raddr;
	logic [VW-1:0] h_waddr, h_raddr, c_waddr, c_raddr;
	logic signed [15:0] w_rdata, b_rdata, s_rdata, o_rdata, g_rdata, h_rdata, c_rdata;
	logic signed [15:0] g_wdata, h_wdata, c_wdata, o_wdata;
	logic signed [15:0] hmask, cmask;

	mac_ctrl_t          mac;
	logic signed [31:0] prod_s1, acc_q;

	logic          rd_req, start;
	logic [1:0]    bias_pos;

	// effective configuration
	always_comb begin
		if (cfg.hidden_size == 6'd0)
			h_eff = CW'(1);
		else if (int'(cfg.hidden_size) > HIDDEN_MAX)
			h_eff = CW'(HIDDEN_MAX);
		else
			h_eff = CW'(cfg.hidden_size);
		if (cfg.input_size == 6'd0)
			n_eff = CW'(1);
		else if (int'(cfg.input_size) > INPUT_MAX)
			n_eff = CW'(INPUT_MAX);
		else
			n_eff = CW'(cfg.input_size);
		l_last = (LAYERS_MAX > 1) && (cfg.layer_count > 2'd1);
		size   = l_q ? h_eff : n_eff;
		slot_i = int'(d_q) * (int'(l_last) + 1) + int'(l_q);
	end

	assign start  = cmd_valid && cmd.mode == MODE_FEATURE && cmd.last_element;
	assign rd_req = cmd_valid && cmd.mode == MODE_READ;

	// load writes
	always_comb begin
		w_we    = cmd_valid && cmd.mode == MODE_WEIGHT && int'(cmd.slot) < SLOTS
			&& int'(cmd.word_addr) < MAT_WORDS;
		w_waddr = WW'((int'(cmd.slot) * 2 + int'(cmd.matrix_sel)) * MAT_WORDS
			+ int'(cmd.word_addr));
		b_we    = cmd_valid && cmd.mode == MODE_BIAS && int'(cmd.slot) < SLOTS
			&& int'(cmd.word_addr) < BIAS_WORDS;
		b_waddr = BW'((int'(cmd.slot) * 2 + int'(cmd.matrix_sel)) * BIAS_WORDS
			+ int'(cmd.word_addr));
		s_we    = cmd_valid && cmd.mode == MODE_FEATURE && int'(cmd.time_step) < STEPS_MAX
			&& int'(cmd.word_addr) < INPUT_MAX;
		s_waddr = SW'(int'(cmd.time_step) * INPUT_MAX + int'(cmd.word_addr));
	end

	assign hmask = hrd_v_s1 ? h_rdata : 16'sd0;
	assign cmask = crd_v_s1 ? c_rdata : 16'sd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// sequencer: next state, memory addresses and shared unit control
	always_comb begin
		state_d  = state_q;
		mac      = '{mul_en: 1'b0, mul_a: 16'sd0, mul_b: 16'sd0, acc_op: ACC_HOLD,
			load_val: 32'sd0};
		w_raddr  = '0;
		b_raddr  = '0;
		s_raddr  = SW'(int'(src_q) * INPUT_MAX + int'(i_q));
		g_raddr  = '0;
		h_raddr  = '0;
		c_raddr  = VW'(int'(l_q) * HIDDEN_MAX + int'(q_q));
		o_raddr  = OW'(int'(cmd.time_step) * OUT_ROW + int'(cmd.word_addr));
		g_we     = 1'b0;
		g_waddr  = GW'(int'(g_q) * HIDDEN_MAX + int'(q_q));
		g_wdata  = sat16_q8(acc_q);
		c_we     = 1'b0;
		c_waddr  = VW'(int'(l_q) * HIDDEN_MAX + int'(q_q));
		c_wdata  = sat16_q8(acc_q);
		h_we     = 1'b0;
		h_waddr  = VW'(int'(l_q) * HIDDEN_MAX + int'(q_q));
		h_wdata  = prod_s1[23:8];
		o_we     = 1'b0;
		o_waddr  = OW'(int'(src_q) * OUT_ROW + int'(d_q) * int'(h_eff) + int'(q_q));
		o_wdata  = prod_s1[23:8];
		bias_pos = (g_q == 2'd1) ? 2'd2 : ((g_q == 2'd2) ? 2'd1 : g_q);
		unique case (state_q)
			ST_IDLE: begin
				if (start)
					state_d = ST_START;
			end
			ST_START: state_d = ST_DIR;
			ST_DIR:   state_d = ST_LAYER;
			ST_LAYER: state_d = ST_UNIT;
			ST_UNIT:  state_d = ST_BH;
			ST_BH: begin
				b_raddr = BW'((slot_i * 2 + 1) * BIAS_WORDS + int'(bias_pos) * int'(h_eff)
					+ int'(q_q));
				state_d = ST_BX;
			end
			ST_BX: begin
				b_raddr = BW'((slot_i * 2) * BIAS_WORDS + int'(g_q) * int'(h_eff)
					+ int'(q_q));
				state_d = ST_BINIT;
			end
			ST_BINIT: begin
				mac.acc_op   = ACC_LOAD;
				mac.load_val = (32'(bh_q) + 32'(b_rdata)) * 32'sd256;
				state_d      = ST_HH_RD;
			end
			ST_HH_RD: begin
				w_raddr = WW'((slot_i * 2 + 1) * MAT_WORDS + int'(rowh_q) + int'(i_q));
				h_raddr = VW'(int'(l_q) * HIDDEN_MAX + int'(i_q));
				state_d = ST_HH_MUL;
			end
			ST_HH_MUL: begin
				mac.mul_en = 1'b1;
				mac.mul_a  = w_rdata;
				mac.mul_b  = hmask;
				state_d    = ST_HH_ACC;
			end
			ST_HH_ACC: begin
				mac.acc_op = ACC_ADD;
				state_d    = (i_q + CW'(1) == h_eff) ? ST_X_RD : ST_HH_RD;
			end
			ST_X_RD: begin
				w_raddr = WW'((slot_i * 2) * MAT_WORDS + int'(rowx_q) + int'(i_q));
				h_raddr = VW'(i_q);
				state_d = ST_X_MUL;
			end
			ST_X_MUL: begin
				mac.mul_en = 1'b1;
				mac.mul_a  = w_rdata;
				mac.mul_b  = l_q ? hmask : s_rdata;
				state_d    = ST_X_ACC;
			end
			ST_X_ACC: begin
				mac.acc_op = ACC_ADD;
				state_d    = (i_q + CW'(1) == size) ? ST_GWR : ST_X_RD;
			end
			ST_GWR: begin
				g_we = 1'b1;
				if (g_q != 2'd3)
					state_d = ST_BH;
				else if (q_q + CW'(1) == h_eff)
					state_d = ST_U_RI;
				else
					state_d = ST_UNIT;
			end
			ST_U_RI: begin
				g_raddr = GW'(q_q);
				state_d = ST_U_RF;
			end
			ST_U_RF: begin
				g_raddr = GW'(HIDDEN_MAX + int'(q_q));
				state_d = ST_U_RG;
			end
			ST_U_RG: begin
				g_raddr = GW'(2 * HIDDEN_MAX + int'(q_q));
				state_d = ST_U_RO;
			end
			ST_U_RO: begin
				g_raddr = GW'(3 * HIDDEN_MAX + int'(q_q));
				state_d = ST_U_M1;
			end
			ST_U_M1: begin
				mac.mul_en   = 1'b1;
				mac.mul_a    = gf_q;
				mac.mul_b    = cmask;
				mac.acc_op   = ACC_LOAD;
				state_d      = ST_U_A1;
			end
			ST_U_A1: begin
				mac.mul_en = 1'b1;
				mac.mul_a  = gi_q;
				mac.mul_b  = gg_q;
				mac.acc_op = ACC_ADD;
				state_d    = ST_U_A2;
			end
			ST_U_A2: begin
				mac.acc_op = ACC_ADD;
				state_d    = ST_U_C;
			end
			ST_U_C: begin
				c_we    = 1'b1;
				state_d = ST_U_H1;
			end
			ST_U_H1: begin
				mac.mul_en = 1'b1;
				mac.mul_a  = go_q;
				mac.mul_b  = TANH_TAB[tab_idx(c_q)];
				state_d    = ST_U_H2;
			end
			ST_U_H2: begin
				h_we = 1'b1;
				o_we = (l_q == l_last);
				if (q_q + CW'(1) != h_eff)
					state_d = ST_U_RI;
				else if (l_q != l_last)
					state_d = ST_LAYER;
				else if (t_q + 7'd1 != steps_q)
					state_d = ST_LAYER;
				else if (cfg.bidirectional && !d_q)
					state_d = ST_DIR;
				else
					state_d = ST_DONE;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer counters and operand registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q       <= 1'b0;
			l_q       <= 1'b0;
			t_q       <= '0;
			q_q       <= '0;
			i_q       <= '0;
			g_q       <= '0;
			steps_q   <= '0;
			hv_q      <= '0;
			cv_q      <= '0;
			rd_pend_q <= 1'b0;
			rd_ok_q   <= 1'b0;
		end else begin
			rd_pend_q <= rd_req;
			rd_ok_q   <= int'(cmd.time_step) < STEPS_MAX && int'(cmd.word_addr) < OUT_ROW;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						d_q     <= 1'b0;
						steps_q <= (int'(cmd.time_step) + 1 > STEPS_MAX) ? 7'(STEPS_MAX)
							: 7'(cmd.time_step) + 7'd1;
					end
				end
				ST_DIR: begin
					hv_q <= '0;
					cv_q <= '0;
					t_q  <= '0;
					l_q  <= 1'b0;
				end
				ST_LAYER: begin
					q_q <= '0;
				end
				ST_UNIT: begin
					g_q <= '0;
					i_q <= '0;
				end
				ST_HH_ACC: begin
					i_q <= (i_q + CW'(1) == h_eff) ? '0 : i_q + CW'(1);
				end
				ST_X_ACC: begin
					i_q <= (i_q + CW'(1) == size) ? '0 : i_q + CW'(1);
				end
				ST_GWR: begin
					g_q <= g_q + 2'd1;
					if (g_q == 2'd3)
						q_q <= (q_q + CW'(1) == h_eff) ? '0 : q_q + CW'(1);
				end
				ST_U_C: begin
					cv_q[c_waddr] <= 1'b1;
				end
				ST_U_H2: begin
					hv_q[h_waddr] <= 1'b1;
					if (q_q + CW'(1) != h_eff) begin
						q_q <= q_q + CW'(1);
					end else if (l_q != l_last) begin
						l_q <= 1'b1;
					end else if (t_q + 7'd1 != steps_q) begin
						t_q <= t_q + 7'd1;
						l_q <= 1'b0;
					end else begin
						d_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		hrd_v_s1 <= hv_q[h_raddr];
		crd_v_s1 <= cv_q[c_raddr];
		unique case (state_q)
			ST_START: hh_q <= MW'(int'(h_eff) * int'(h_eff));
			ST_LAYER: begin
				src_q <= d_q ? steps_q - 7'd1 - t_q : t_q;
				hs_q  <= MW'(int'(h_eff) * int'(size));
				qs_q  <= '0;
				qh_q  <= '0;
			end
			ST_UNIT: begin
				rowx_q <= qs_q;
				rowh_q <= qh_q;
			end
			ST_BX: bh_q <= b_rdata;
			ST_GWR: begin
				rowx_q <= rowx_q + hs_q;
				rowh_q <= rowh_q + hh_q;
				if (g_q == 2'd3) begin
					qs_q <= qs_q + MW'(size);
					qh_q <= qh_q + MW'(h_eff);
				end
			end
			ST_U_RF: gi_q <= SIG_TAB[tab_idx(g_rdata)];
			ST_U_RG: gf_q <= SIG_TAB[tab_idx(g_rdata)];
			ST_U_RO: gg_q <= TANH_TAB[tab_idx(g_rdata)];
			ST_U_M1: go_q <= SIG_TAB[tab_idx(g_rdata)];
			ST_U_C:  c_q  <= c_wdata;
			default: ;
		endcase
	end

	always_comb begin
		res = '{valid: 1'b0, kind: KIND_DONE, value: 16'sd0};
		if (state_q == ST_DONE) begin
			res.valid = 1'b1;
			res.value = 16'(steps_q);
		end else if (rd_pend_q) begin
			res.valid = 1'b1;
			res.kind  = KIND_READ;
			res.value = rd_ok_q ? o_rdata : 16'sd0;
		end
	end

	assign busy = (state_q != ST_IDLE) || rd_pend_q;

	blsu_mac u_mac (.clk(clk), .ctrl(mac), .prod_s1(prod_s1), .acc_q(acc_q));

	blsu_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_wram (.clk(clk), .we(w_we), .waddr(w_waddr),
		.wdata(cmd.data_value), .raddr(w_raddr), .rdata(w_rdata));
	blsu_ram #(.WIDTH(16), .DEPTH(B_DEPTH)) u_bram (.clk(clk), .we(b_we), .waddr(b_waddr),
		.wdata(cmd.data_value), .raddr(b_raddr), .rdata(b_rdata));
	blsu_ram #(.WIDTH(16), .DEPTH(S_DEPTH)) u_sram (.clk(clk), .we(s_we), .waddr(s_waddr),
		.wdata(cmd.data_value), .raddr(s_raddr), .rdata(s_rdata));
	blsu_ram #(.WIDTH(16), .DEPTH(O_DEPTH)) u_oram (.clk(clk), .we(o_we), .waddr(o_waddr),
		.wdata(o_wdata), .raddr(o_raddr), .rdata(o_rdata));
	blsu_ram #(.WIDTH(16), .DEPTH(G_DEPTH)) u_gram (.clk(clk), .we(g_we), .waddr(g_waddr),
		.wdata(g_wdata), .raddr(g_raddr), .rdata(g_rdata));
	blsu_ram #(.WIDTH(16), .DEPTH(V_DEPTH)) u_hram (.clk(clk), .we(h_we), .waddr(h_waddr),
		.wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata));
	blsu_ram #(.WIDTH(16), .DEPTH(V_DEPTH)) u_cram (.clk(clk), .we(c_we), .waddr(c_waddr),
		.wdata(c_wdata), .raddr(c_raddr), .rdata(c_rdata));
endmodule
`default_nettype wire

// ----- hdl/bidirectional_lstm_sequence_unit.sv -----
`default_nettype none
// Channel   Direction  Handshake          Payload
// in        request    in_valid/in_stall  mode slot matrix_sel time_step word_addr
//                                         data_value last_element
// out       result     out_valid/out_stall result_kind result_value
// config    APB write  psel/penable/pwrite paddr pwdata (prdata on read)
//
// Weight, bias and feature loads leave the input free; a read stalls it while its
// result is pending. A feature marked last runs the sequence on one shared
// multiply-accumulate unit: per gate a bias load, hidden and input products and a
// write; four gates, then a state update, per hidden unit, for every layer, time step
// and direction. Reset clears the sequencer and out_valid, sets default configuration
// and keeps stores. A stalled result holds the output register and blocks the next item.
module bidirectional_lstm_sequence_unit #(
	parameter int HIDDEN_MAX = blsu_pkg::HIDDEN_MAX_DEF,
	parameter int INPUT_MAX  = blsu_pkg::INPUT_MAX_DEF,
	parameter int STEPS_MAX  = blsu_pkg::STEPS_MAX_DEF,
	parameter int LAYERS_MAX = blsu_pkg::LAYERS_MAX_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         mode,
	input  wire logic [1:0]         slot,
	input  wire logic               matrix_sel,
	input  wire logic [5:0]         time_step,
	input  wire logic [11:0]        word_addr,
	input  wire logic signed [15:0] data_value,
	input  wire logic               last_element,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    result_kind,
	output logic signed [15:0]      result_value
);
	import blsu_pkg::*;

	cfg_t  cfg_q;
	item_t cmd;
	res_t  res;
	logic  busy, accept, out_valid_q, kind_q;
	logic signed [15:0] value_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{layer_count: 2'd1, bidirectional: 1'b0, hidden_size: 6'd32,
				input_size: 6'd32};
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_LAYERS: cfg_q.layer_count   <= pwdata[1:0];
				REG_BIDIR:  cfg_q.bidirectional <= pwdata[0];
				REG_HIDDEN: cfg_q.hidden_size   <= pwdata[5:0];
				REG_INPUT:  cfg_q.input_size    <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_LAYERS: prdata = 32'(cfg_q.layer_count);
			REG_BIDIR:  prdata = 32'(cfg_q.bidirectional);
			REG_HIDDEN: prdata = 32'(cfg_q.hidden_size);
			REG_INPUT:  prdata = 32'(cfg_q.input_size);
			default:    prdata = 32'd0;
		endcase
	end

	// hold off while busy or while a result is still waiting
	assign in_stall = busy || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign cmd = '{mode: mode, slot: slot, matrix_sel: matrix_sel, time_step: time_step,
		word_addr: word_addr, data_value: data_value, last_element: last_element};

	blsu_core #(
		.HIDDEN_MAX(HIDDEN_MAX),
		.INPUT_MAX(INPUT_MAX),
		.STEPS_MAX(STEPS_MAX),
		.LAYERS_MAX(LAYERS_MAX)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd(cmd),
		.cmd_valid(accept),
		.res(res),
		.busy(busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res.valid)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			kind_q  <= res.kind;
			value_q <= res.value;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign result_value = value_q;

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == MODE_FEATURE && last_element) |=> busy)
		else $error("run did not start after last feature");
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !out_valid_q)
		else $error("result would overwrite pending output");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall)
		else $error("item taken while busy");
	a_read_out: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == MODE_READ) |-> ##2 out_valid)
		else $error("read gave no result");
endmodule
`default_nettype wire
